// ===== sv/url_dec_pkg.sv =====
// Package for the URL percent decoder: mode codes, error codes, escape phase type, character classes.
`timescale 1ns / 1ps

package url_dec_pkg;

	localparam int unsigned MODE_W = 3;
	localparam int unsigned ERR_W  = 2;

	localparam logic [MODE_W-1:0] MODE_PATH     = 3'd0;
	localparam logic [MODE_W-1:0] MODE_SEGMENT  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HOST     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ZONE     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_USERINFO = 3'd4;
	localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd5;
	localparam logic [MODE_W-1:0] MODE_FRAGMENT = 3'd6;

	localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_ESCAPE = 2'd1;
	localparam logic [ERR_W-1:0] ERR_HOST   = 2'd2;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_PCT  = 2'd1,
		PH_HEX1 = 2'd2
	} esc_phase_t;

	function automatic logic is_hex(input logic [7:0] c);
		is_hex = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
		end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = c[3:0] + 4'd9;
		end
		hex_value = v;
	endfunction

	// letters, digits, - _ . ~ ! $ & ' ( ) * + , ; = : [ ] < > "
	function automatic logic host_allowed(input logic [7:0] c);
		logic ok;
		ok = 1'b0;
		case (c) inside
			[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]: ok = 1'b1;
			8'h21, 8'h22, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
			8'h2C, 8'h2D, 8'h2E, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
			8'h5B, 8'h5D, 8'h5F, 8'h7E: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		host_allowed = ok;
	endfunction

endpackage

// ===== sv/url_percent_decoder_core.sv =====
// URL percent decoder: one raw byte in, one decoded result out per transaction.
`timescale 1ns / 1ps

// Decodes one URL component, one byte per transaction, and gives one result per
// input byte in the cycle after acceptance; a new byte is taken every cycle while the
// output side is ready. "%hh" yields its byte on the second hex digit; '+' becomes a
// space in query mode. Host and zone modes check bare and escaped characters. Any
// error is sticky to the end of the string (tlast) and suppresses the bytes until
// then; tuser carries the error code on every result of that span. Write the mode
// register only while no string is in progress; the block itself does not enforce it.
module url_percent_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_wr_data,    // decode_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
	input  logic        s_axis_tlast,   // in_last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
	output logic        m_axis_tlast,   // out_last
	output logic [2:0]  m_axis_tuser    // [0] out_valid, [2:1] error_code
);
	import url_dec_pkg::*;

	logic [MODE_W-1:0] mode_q;
	esc_phase_t        phase_q, phase_d;
	logic [3:0]        hi_q, hi_d;
	logic [ERR_W-1:0]  sticky_q, sticky_d;

	logic              out_vld_q;
	logic [7:0]        out_byte_q;
	logic              out_last_q;
	logic              out_flag_q;
	logic [ERR_W-1:0]  out_err_q;

	logic              accept;
	logic [7:0]        ob;
	logic              ov;
	logic [ERR_W-1:0]  err;
	logic [ERR_W-1:0]  err_out;
	logic              hostish;
	logic [7:0]        val;
	logic              dig_ok;
	logic [3:0]        dig;

	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign hostish       = (mode_q == MODE_HOST) || (mode_q == MODE_ZONE);
	assign dig_ok        = is_hex(s_axis_tdata);
	assign dig           = hex_value(s_axis_tdata);
	assign val           = {hi_q, dig};

	always_comb begin
		ob       = 8'd0;
		ov       = 1'b0;
		err      = ERR_NONE;
		phase_d  = phase_q;
		hi_d     = hi_q;
		sticky_d = sticky_q;
		if (sticky_q == ERR_NONE) begin
			case (phase_q)
				PH_IDLE: begin
					if (s_axis_tdata == CH_PERCENT) begin
						phase_d = PH_PCT;
						if (s_axis_tlast) err = ERR_ESCAPE;
					end else if (s_axis_tdata == CH_PLUS) begin
						ob = (mode_q == MODE_QUERY) ? CH_SPACE : CH_PLUS;
						ov = 1'b1;
					end else if (hostish && !s_axis_tdata[7] && !host_allowed(s_axis_tdata)) begin
						err = ERR_HOST;
					end else begin
						ob = s_axis_tdata;
						ov = 1'b1;
					end
				end
				PH_PCT: begin
					if (!dig_ok) begin
						err = ERR_ESCAPE;
					end else begin
						hi_d    = dig;
						phase_d = PH_HEX1;
						if (s_axis_tlast) err = ERR_ESCAPE;
					end
				end
				default: begin
					if (!dig_ok) begin
						err = ERR_ESCAPE;
					end else begin
						if (mode_q == MODE_HOST && !hi_q[3] && val != CH_PERCENT) begin
							err = ERR_ESCAPE;
						end else if (mode_q == MODE_ZONE && val != CH_PERCENT &&
								val != CH_SPACE && !host_allowed(val)) begin
							err = ERR_ESCAPE;
						end else begin
							ob = val;
							ov = 1'b1;
						end
						phase_d = PH_IDLE;
					end
				end
			endcase
			if (err != ERR_NONE) begin
				sticky_d = err;
				phase_d  = PH_IDLE;
				ob       = 8'd0;
				ov       = 1'b0;
			end
		end
		err_out = sticky_d;
		if (s_axis_tlast) begin
			phase_d  = PH_IDLE;
			hi_d     = 4'd0;
			sticky_d = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PATH;
			phase_q  <= PH_IDLE;
			hi_q     <= 4'd0;
			sticky_q <= ERR_NONE;
		end else begin
			if (cfg_wr_en) mode_q <= cfg_wr_data;
			if (accept) begin
				phase_q  <= phase_d;
				hi_q     <= hi_d;
				sticky_q <= sticky_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= ob;
			out_flag_q <= ov;
			out_last_q <= s_axis_tlast;
			out_err_q  <= err_out;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = {out_err_q, out_flag_q};

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tlast) |=> (phase_q == PH_IDLE && sticky_q == ERR_NONE && hi_q == 4'd0))
		else $error("state not cleared after end of string");

	a_err_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sticky_q != ERR_NONE) |-> (phase_q == PH_IDLE))
		else $error("escape in progress while error is held");

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2:1] != ERR_NONE) |-> !m_axis_tuser[0])
		else $error("decoded byte flagged during error span");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 8'd0))
		else $error("suppressed result carries nonzero byte");

endmodule
